### src/wbt_pkg.sv
// ----------------------------------------------------------------------------
// wbt_pkg
// Shared types and constants of the wireless beacon timer.
// ----------------------------------------------------------------------------
package wbt_pkg;

  localparam int unsigned ActW    = 3;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [ActW-1:0] ACT_TICK      = 3'd0;
  localparam logic [ActW-1:0] ACT_LOAD_CNT  = 3'd1;
  localparam logic [ActW-1:0] ACT_CLR_FLAGS = 3'd2;
  localparam logic [ActW-1:0] ACT_SET_FLAGS = 3'd3;
  localparam logic [ActW-1:0] ACT_BEACON    = 3'd4;
  localparam logic [ActW-1:0] ACT_LOAD_BCN  = 3'd5;
  localparam logic [ActW-1:0] ACT_LOAD_CONT = 3'd6;

  localparam logic [CfgIdxW-1:0] REG_COUNT_EN   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_COMPARE_EN = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_COMPARE    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_BCN_INT    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_LISTEN_INT = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_PRE_BEACON = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_IRQ_EN     = 3'd6;

  localparam logic [9:0]  MS_MASK    = 10'h3FF;
  localparam logic [15:0] SET_MASK   = 16'hFBFF;
  localparam logic [15:0] POST_START = 16'hFFFF;
  localparam int unsigned POST_BIT   = 13;
  localparam int unsigned BEACON_BIT = 14;
  localparam int unsigned PRE_BIT    = 15;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef enum logic [2:0] {
    OP_TICK,
    OP_LOAD_CNT,
    OP_CLR_FLAGS,
    OP_SET_FLAGS,
    OP_BEACON,
    OP_LOAD_BCN,
    OP_LOAD_CONT,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [63:0] value;
  } cmd_t;

  typedef struct packed {
    logic        count_en;
    logic        compare_en;
    logic [63:0] compare_value;
    logic [15:0] beacon_interval;
    logic [15:0] listen_interval;
    logic [15:0] pre_beacon;
    logic [15:0] irq_enable;
  } cfg_t;

  typedef struct packed {
    logic        irq_raise;
    logic [15:0] irq_flags;
    logic [63:0] counter_now;
    logic [15:0] beacon_left;
    logic [15:0] post_beacon_left;
    logic [15:0] listen_left;
    logic [15:0] contention_left;
  } res_t;

endpackage

### src/wbt_regs.sv
// ----------------------------------------------------------------------------
// wbt_regs
// Configuration register file, written through its own valid/ready channel.
// ----------------------------------------------------------------------------
module wbt_regs import wbt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [63:0]        cfg_data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_COUNT_EN:   cfg_d.count_en        = cfg_data_i[0];
        REG_COMPARE_EN: cfg_d.compare_en      = cfg_data_i[0];
        REG_COMPARE:    cfg_d.compare_value   = {cfg_data_i[63:10], ~MS_MASK & 10'h000};
        REG_BCN_INT:    cfg_d.beacon_interval = cfg_data_i[15:0];
        REG_LISTEN_INT: cfg_d.listen_interval = cfg_data_i[15:0];
        REG_PRE_BEACON: cfg_d.pre_beacon      = cfg_data_i[15:0];
        REG_IRQ_EN:     cfg_d.irq_enable      = cfg_data_i[15:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### src/wbt_front.sv
// ----------------------------------------------------------------------------
// wbt_front
// Accept input words and classify the action into an operation for the queue.
// ----------------------------------------------------------------------------
module wbt_front import wbt_pkg::*; (
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [ActW-1:0] action_i,
  input  logic [63:0]     value_i,
  output logic            push_o,
  input  logic            push_ready_i,
  output cmd_t            cmd_o
);

  assign in_ready_o = push_ready_i;
  assign push_o     = in_valid_i && push_ready_i;

  always_comb begin
    cmd_o.value = value_i;
    case (action_i)
      ACT_TICK:      cmd_o.op = OP_TICK;
      ACT_LOAD_CNT:  cmd_o.op = OP_LOAD_CNT;
      ACT_CLR_FLAGS: cmd_o.op = OP_CLR_FLAGS;
      ACT_SET_FLAGS: cmd_o.op = OP_SET_FLAGS;
      ACT_BEACON:    cmd_o.op = OP_BEACON;
      ACT_LOAD_BCN:  cmd_o.op = OP_LOAD_BCN;
      ACT_LOAD_CONT: cmd_o.op = OP_LOAD_CONT;
      default:       cmd_o.op = OP_NOP;
    endcase
  end

endmodule

### src/wbt_queue.sv
// ----------------------------------------------------------------------------
// wbt_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module wbt_queue import wbt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  output logic push_ready_o,
  input  cmd_t push_cmd_i,
  output logic pop_valid_o,
  input  logic pop_i,
  output cmd_t pop_cmd_o
);

  cmd_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;

  assign push_ready_o = (cnt_q != QCntW'(QDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_cmd_o    = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QDepth))
    else $error("queue count above depth");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> pop_valid_o)
    else $error("pop from empty queue");

  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue count lost a push");

endmodule

### src/wbt_back.sv
// ----------------------------------------------------------------------------
// wbt_back
// Execute queued operations on the timer state and register the result word.
// ----------------------------------------------------------------------------
module wbt_back import wbt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic cmd_valid_i,
  output logic cmd_pop_o,
  input  cmd_t cmd_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t res_o
);

  typedef struct packed {
    logic [63:0] cnt;
    logic [15:0] flags;
    logic [15:0] bcn;
    logic [15:0] post;
    logic [15:0] lst;
    logic [15:0] cont;
  } state_t;

  state_t      st_q, st_d;
  logic        out_valid_q;
  res_t        res_q, res_d;
  logic [63:0] cnt_inc;
  logic [9:0]  part;
  logic        raise_ok;

  function automatic logic [15:0] listen_step(logic [15:0] cur, logic [15:0] reload);
    logic [15:0] base;
    base = (cur == '0) ? reload : cur;
    return base - 16'd1;
  endfunction

  assign cmd_pop_o   = cmd_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;
  assign cnt_inc     = st_q.cnt + 64'd1;
  assign part        = cnt_inc[9:0] & MS_MASK;

  always_comb begin
    st_d     = st_q;
    raise_ok = 1'b0;
    case (cmd_i.op)
      OP_TICK: begin
        raise_ok = 1'b1;
        if (cfg_i.count_en) begin
          st_d.cnt = cnt_inc;
          if (cfg_i.compare_en && (cnt_inc == cfg_i.compare_value)) begin
            st_d.flags[BEACON_BIT] = 1'b1;
            st_d.bcn               = cfg_i.beacon_interval;
            st_d.post              = POST_START;
            st_d.lst               = listen_step(st_d.lst, cfg_i.listen_interval);
          end
          if (cfg_i.compare_en && (st_d.bcn[15:6] == '0) &&
              ({st_d.bcn[5:0], ~part} == cfg_i.pre_beacon)) begin
            st_d.flags[PRE_BIT] = 1'b1;
          end
          if (part == '0) begin
            st_d.bcn = st_d.bcn - 16'd1;
            if (cfg_i.compare_en && (st_d.bcn == '0)) begin
              st_d.flags[BEACON_BIT] = 1'b1;
              st_d.bcn               = cfg_i.beacon_interval;
              st_d.post              = POST_START;
              st_d.lst               = listen_step(st_d.lst, cfg_i.listen_interval);
            end
            if (st_d.post != '0) begin
              st_d.post = st_d.post - 16'd1;
              if (st_d.post == '0) begin
                st_d.flags[POST_BIT] = 1'b1;
              end
            end
          end
        end
        if (st_q.cont != '0) begin
          st_d.cont = st_q.cont - 16'd1;
        end
      end
      OP_LOAD_CNT:  st_d.cnt   = cmd_i.value;
      OP_CLR_FLAGS: st_d.flags = st_q.flags & ~cmd_i.value[15:0];
      OP_SET_FLAGS: st_d.flags = st_q.flags | (cmd_i.value[15:0] & SET_MASK);
      OP_BEACON: begin
        raise_ok               = 1'b1;
        st_d.flags[BEACON_BIT] = 1'b1;
        st_d.post              = POST_START;
        st_d.lst               = listen_step(st_q.lst, cfg_i.listen_interval);
      end
      OP_LOAD_BCN:  st_d.bcn  = cmd_i.value[15:0];
      OP_LOAD_CONT: st_d.cont = cmd_i.value[15:0];
      OP_NOP:       st_d = st_q;
      default:      st_d = st_q;
    endcase

    res_d.irq_raise        = raise_ok && ((st_q.flags & cfg_i.irq_enable) == '0) &&
                             ((st_d.flags & cfg_i.irq_enable) != '0);
    res_d.irq_flags        = st_d.flags;
    res_d.counter_now      = st_d.cnt;
    res_d.beacon_left      = st_d.bcn;
    res_d.post_beacon_left = st_d.post;
    res_d.listen_left      = st_d.lst;
    res_d.contention_left  = st_d.cont;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_pop_o) begin
        st_q        <= st_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      res_q <= res_d;
    end
  end

  a_pop_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |=> out_valid_q)
    else $error("executed word not presented");

  a_raise_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_pop_o && res_d.irq_raise) |-> (cmd_i.op == OP_TICK || cmd_i.op == OP_BEACON))
    else $error("raise from a flag write or load");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_pop_o |=> $stable(st_q))
    else $error("state moved without an operation");

endmodule

### src/wireless_beacon_timer_core.sv
// ----------------------------------------------------------------------------
// wireless_beacon_timer_core
// Microsecond timer with beacon, pre-beacon and post-beacon interrupt flags.
// ----------------------------------------------------------------------------
// One word is accepted per cycle and one result word leaves per cycle when the
// output side keeps taking; an accepted word passes the queue and the result
// register before its result shows. The back end sets the sustained rate: it
// applies a whole word (64-bit increment and compare, beacon and countdown
// updates) to the timer state combinationally. A two-entry queue and the output
// register let the input and output sides stall independently.
module wireless_beacon_timer_core import wbt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [ActW-1:0]    action_i,
  input  logic [63:0]        value_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [63:0]        cfg_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               irq_raise_o,
  output logic [15:0]        irq_flags_o,
  output logic [63:0]        counter_now_o,
  output logic [15:0]        beacon_left_o,
  output logic [15:0]        post_beacon_left_o,
  output logic [15:0]        listen_left_o,
  output logic [15:0]        contention_left_o
);

  cfg_t cfg;
  cmd_t push_cmd;
  cmd_t pop_cmd;
  res_t res;
  logic push;
  logic push_ready;
  logic pop_valid;
  logic pop;

  wbt_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  wbt_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .value_i      (value_i),
    .push_o       (push),
    .push_ready_i (push_ready),
    .cmd_o        (push_cmd)
  );

  wbt_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_cmd_o    (pop_cmd)
  );

  wbt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_valid_i (pop_valid),
    .cmd_pop_o   (pop),
    .cmd_i       (pop_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign irq_raise_o        = res.irq_raise;
  assign irq_flags_o        = res.irq_flags;
  assign counter_now_o      = res.counter_now;
  assign beacon_left_o      = res.beacon_left;
  assign post_beacon_left_o = res.post_beacon_left;
  assign listen_left_o      = res.listen_left;
  assign contention_left_o  = res.contention_left;

endmodule

### tb/wbt_timer_checker.sv
// ----------------------------------------------------------------------------
// wbt_timer_checker
// Follows the register writes and the words on the input channel of the
// beacon timer, works out the timer state that each word must report, and
// compares every output word with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module wbt_timer_checker import wbt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [ActW-1:0]    action_i,
  input  logic [63:0]        value_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [63:0]        cfg_data_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  res_t               result_i,
  output int                 mismatches_o,
  output int                 outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  cfg_t        regs;
  logic [63:0] us_count;
  logic [15:0] flags;
  logic [15:0] bcn_left;
  logic [15:0] post_left;
  logic [15:0] listen_left;
  logic [15:0] cfp_left;
  logic        raised;
  res_t        predicted_q[$];
  int          word_no;

  function automatic void mark_flag(int unsigned pos);
    logic [15:0] seen;
    seen = flags & regs.irq_enable;
    flags[pos] = 1'b1;
    if (seen == '0 && (flags & regs.irq_enable) != '0) raised = 1'b1;
  endfunction

  function automatic void beacon_hit(bit forced);
    mark_flag(BEACON_BIT);
    if (!forced) bcn_left = regs.beacon_interval;
    post_left = POST_START;
    if (listen_left == '0) listen_left = regs.listen_interval;
    listen_left = listen_left - 16'd1;
  endfunction

  function automatic void ms_elapsed();
    bcn_left = bcn_left - 16'd1;
    if (regs.compare_en && bcn_left == '0) beacon_hit(1'b0);
    if (post_left != '0) begin
      post_left = post_left - 16'd1;
      if (post_left == '0) mark_flag(POST_BIT);
    end
  endfunction

  function automatic void us_tick();
    logic [9:0] frac;
    if (regs.count_en) begin
      us_count = us_count + 64'd1;
      frac = us_count[9:0];
      if (regs.compare_en) begin
        if (us_count == regs.compare_value) beacon_hit(1'b0);
        if ({bcn_left, MS_MASK - frac} == {10'd0, regs.pre_beacon}) mark_flag(PRE_BIT);
      end
      if (frac == '0) ms_elapsed();
    end
    if (cfp_left != '0) cfp_left = cfp_left - 16'd1;
  endfunction

  function automatic res_t apply_word(op_e op, logic [63:0] val);
    res_t r;
    raised = 1'b0;
    case (op)
      OP_TICK:      us_tick();
      OP_LOAD_CNT:  us_count = val;
      OP_CLR_FLAGS: flags = flags & ~val[15:0];
      OP_SET_FLAGS: flags = flags | (val[15:0] & SET_MASK);
      OP_BEACON:    beacon_hit(1'b1);
      OP_LOAD_BCN:  bcn_left = val[15:0];
      OP_LOAD_CONT: cfp_left = val[15:0];
      default: ;
    endcase
    r.irq_raise        = raised;
    r.irq_flags        = flags;
    r.counter_now      = us_count;
    r.beacon_left      = bcn_left;
    r.post_beacon_left = post_left;
    r.listen_left      = listen_left;
    r.contention_left  = cfp_left;
    return r;
  endfunction

  function automatic void write_reg(logic [CfgIdxW-1:0] idx, logic [63:0] data);
    case (idx)
      REG_COUNT_EN:   regs.count_en        = data[0];
      REG_COMPARE_EN: regs.compare_en      = data[0];
      REG_COMPARE:    regs.compare_value   = {data[63:10], 10'd0};
      REG_BCN_INT:    regs.beacon_interval = data[15:0];
      REG_LISTEN_INT: regs.listen_interval = data[15:0];
      REG_PRE_BEACON: regs.pre_beacon      = data[15:0];
      REG_IRQ_EN:     regs.irq_enable      = data[15:0];
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (mismatches_o < 40) begin
      $display("word %0d: %s is %h, expected %h", word_no, what, got, want);
    end
    mismatches_o++;
  endtask

  task automatic compare_word(res_t got);
    res_t want;
    word_no++;
    if (predicted_q.size() == 0) begin
      report_mismatch("unexpected word, counter", got.counter_now, '0);
      return;
    end
    want = predicted_q.pop_front();
    if (got.irq_raise !== want.irq_raise)
      report_mismatch("irq_raise", 64'(got.irq_raise), 64'(want.irq_raise));
    if (got.irq_flags !== want.irq_flags)
      report_mismatch("irq_flags", 64'(got.irq_flags), 64'(want.irq_flags));
    if (got.counter_now !== want.counter_now)
      report_mismatch("counter_now", got.counter_now, want.counter_now);
    if (got.beacon_left !== want.beacon_left)
      report_mismatch("beacon_left", 64'(got.beacon_left), 64'(want.beacon_left));
    if (got.post_beacon_left !== want.post_beacon_left)
      report_mismatch("post_beacon_left", 64'(got.post_beacon_left),
                      64'(want.post_beacon_left));
    if (got.listen_left !== want.listen_left)
      report_mismatch("listen_left", 64'(got.listen_left), 64'(want.listen_left));
    if (got.contention_left !== want.contention_left)
      report_mismatch("contention_left", 64'(got.contention_left),
                      64'(want.contention_left));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs         = '0;
      us_count     = '0;
      flags        = '0;
      bcn_left     = '0;
      post_left    = '0;
      listen_left  = '0;
      cfp_left     = '0;
      raised       = 1'b0;
      word_no      = 0;
      mismatches_o = 0;
      predicted_q.delete();
      outstanding_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) compare_word(result_i);
      if (cfg_valid_i && cfg_ready_i) write_reg(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_i) begin
        predicted_q.push_back(apply_word(op_e'(action_i), value_i));
      end
      outstanding_o <= predicted_q.size();
    end
  end

endmodule

### tb/tb_wireless_beacon_timer_core.sv
// ----------------------------------------------------------------------------
// tb_wireless_beacon_timer_core
// Drives the beacon timer with a directed opening, random phases under
// several register settings and a receiver hold-off that backs up the input;
// the checker judges every output word.
// ----------------------------------------------------------------------------
module tb_wireless_beacon_timer_core;
  import wbt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HoldCycles = 400;
  localparam int PhaseWords = 265;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic [ActW-1:0]    action    = ACT_TICK;
  logic [63:0]        value     = '0;
  logic               cfg_valid = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = REG_COUNT_EN;
  logic [63:0]        cfg_data  = '0;
  logic               out_ready = 1'b0;

  logic        in_ready;
  logic        cfg_ready;
  logic        out_valid;
  logic        irq_raise;
  logic [15:0] irq_flags;
  logic [63:0] counter_now;
  logic [15:0] beacon_left;
  logic [15:0] post_beacon_left;
  logic [15:0] listen_left;
  logic [15:0] contention_left;

  int mismatches;
  int outstanding;
  int sent       = 0;
  int hold_asked = 0;
  int hold_done  = 0;
  bit calm       = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  wireless_beacon_timer_core DUT (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .action_i           (action),
    .value_i            (value),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .irq_raise_o        (irq_raise),
    .irq_flags_o        (irq_flags),
    .counter_now_o      (counter_now),
    .beacon_left_o      (beacon_left),
    .post_beacon_left_o (post_beacon_left),
    .listen_left_o      (listen_left),
    .contention_left_o  (contention_left)
  );

  wbt_timer_checker timer_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .action_i      (action),
    .value_i       (value),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .result_i      ({irq_raise, irq_flags, counter_now, beacon_left, post_beacon_left,
                     listen_left, contention_left}),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic cfg_t random_settings();
    cfg_t c;
    c.count_en        = ($urandom_range(9) != 0);
    c.compare_en      = ($urandom_range(4) != 0);
    c.compare_value   = rand64();
    c.beacon_interval = $urandom_range(1) ? 16'($urandom_range(1, 4)) : 16'($urandom());
    c.listen_interval = $urandom_range(3) ? 16'($urandom_range(5)) : 16'($urandom());
    c.pre_beacon      = $urandom_range(3) ?
                        16'($urandom_range(3) * 1024 + $urandom_range(31)) : 16'($urandom());
    c.irq_enable      = 16'($urandom());
    return c;
  endfunction

  task automatic send_word(input op_e act, input logic [63:0] val);
    while (!calm && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    value    <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic program_regs(input cfg_t s);
    logic [63:0] junk;
    junk = rand64();
    write_reg(REG_COUNT_EN, {junk[63:1], s.count_en});
    write_reg(REG_COMPARE_EN, {junk[62:0], s.compare_en});
    write_reg(REG_COMPARE, s.compare_value);
    write_reg(REG_BCN_INT, {junk[63:16], s.beacon_interval});
    write_reg(REG_LISTEN_INT, {junk[47:0], s.listen_interval});
    write_reg(REG_PRE_BEACON, {junk[55:8], s.pre_beacon});
    write_reg(REG_IRQ_EN, {junk[51:4], s.irq_enable});
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_run(input cfg_t s);
    int          pick;
    logic [9:0]  frac;
    logic [63:0] hi;
    pick = $urandom_range(99);
    hi   = rand64();
    if (pick < 60 && $urandom_range(3) == 0) send_word(OP_CLR_FLAGS, {hi[63:16], 16'hFFFF});
    if (pick < 30) begin
      if ($urandom_range(1) == 0) send_word(OP_LOAD_BCN, {hi[63:16], 16'($urandom_range(3))});
      send_word(OP_LOAD_CNT, {hi[63:10], MS_MASK - 10'($urandom_range(15))});
      repeat ($urandom_range(1, 20)) send_word(OP_TICK, rand64());
    end else if (pick < 45) begin
      send_word(OP_LOAD_CNT, {s.compare_value[63:10], 10'd0} - 64'($urandom_range(1, 12)));
      repeat ($urandom_range(1, 16)) send_word(OP_TICK, rand64());
    end else if (pick < 60) begin
      frac = MS_MASK - s.pre_beacon[9:0] - 10'($urandom_range(1, 4));
      send_word(OP_LOAD_BCN, {hi[63:16], 10'd0, s.pre_beacon[15:10]});
      send_word(OP_LOAD_CNT, {hi[63:10], frac});
      repeat ($urandom_range(1, 8)) send_word(OP_TICK, rand64());
    end else if (pick < 70) begin
      send_word(OP_LOAD_CONT,
                {hi[63:16], ($urandom_range(1) == 0) ? 16'($urandom_range(5)) : hi[15:0]});
      repeat ($urandom_range(1, 8)) send_word(OP_TICK, rand64());
    end else begin
      send_word(op_e'($urandom_range(7)), hi);
    end
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (hold_asked != hold_done) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_done++;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 11);
      end
    end
  end

  initial begin
    #40ms;
    $display("simulation failed");
    $finish;
  end

  initial begin
    cfg_t s;
    int   target;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    s = '{count_en: 1'b1, compare_en: 1'b1, compare_value: 64'h0BFF, beacon_interval: 16'd2,
          listen_interval: 16'd3, pre_beacon: 16'd5, irq_enable: 16'hFFFF};
    program_regs(s);
    send_word(OP_TICK, '0);
    send_word(OP_LOAD_CNT, 64'h7FF);
    send_word(OP_TICK, '1);
    send_word(OP_SET_FLAGS, '1);
    send_word(OP_CLR_FLAGS, '1);
    send_word(OP_SET_FLAGS, '0);
    send_word(OP_CLR_FLAGS, '0);
    send_word(OP_LOAD_BCN, 64'd1);
    send_word(OP_LOAD_CNT, 64'h3FF);
    send_word(OP_TICK, '0);
    send_word(OP_BEACON, '1);
    send_word(OP_LOAD_BCN, '1);
    send_word(OP_LOAD_CNT, '1);
    send_word(OP_TICK, '0);
    send_word(OP_LOAD_CONT, '1);
    send_word(OP_TICK, '0);
    send_word(OP_LOAD_CONT, '0);
    send_word(OP_TICK, '1);
    send_word(OP_CLR_FLAGS, '1);
    send_word(OP_LOAD_BCN, '0);
    send_word(OP_LOAD_CNT, 64'h3F9);
    send_word(OP_TICK, '0);
    send_word(OP_NOP, '1);
    send_word(OP_LOAD_CNT, '0);
    send_word(OP_NOP, '0);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      if (ph == 0) s = '0;
      else if (ph == 1) s = '1;
      else s = random_settings();
      program_regs(s);
      calm = (ph == 3);
      if (ph == 2) hold_asked++;
      target = sent + PhaseWords;
      while (sent < target) random_run(s);
      drain();
    end
    calm = 1'b0;

    repeat (20) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
